@@ src/parb_pkg.sv @@
`default_nettype none

package parb_pkg;

  // opcode carried in s_tuser
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_PULL  = 2'd2,
    OP_STOP  = 2'd3
  } parb_op_t;

  // configuration register indexes
  localparam logic [1:0] REG_PREBUFFER = 2'd0;
  localparam logic [1:0] REG_MAX_BUF   = 2'd1;
  localparam logic [1:0] REG_PER_TICK  = 2'd2;

  localparam int CfgWidth   = 15;
  localparam int LevelWidth = 15;
  localparam int SampleWidth = 16;
  localparam int TimeWidth  = 48;

  localparam logic [CfgWidth-1:0] PREBUFFER_RESET = 15'd3840;
  localparam logic [CfgWidth-1:0] MAX_BUF_RESET   = 15'd9600;
  localparam logic [CfgWidth-1:0] PER_TICK_RESET  = 15'd480;

  // status of one step, sample word travels apart from the ram
  typedef struct packed {
    logic                  sample_valid;
    logic                  dropped_oldest;
    logic                  deliver;
    logic [LevelWidth-1:0] trimmed_frames;
    logic [LevelWidth-1:0] fill_level;
    logic                  running;
  } parb_result_t;

endpackage

`default_nettype wire

@@ src/paced_audio_ring_buffer_unit.sv @@
`default_nettype none

// paced audio ring: overwrite-oldest sample ring with playout pacing
// input stream: s_tuser holds the opcode (write, tick, pull, stop), s_tdata
//   holds the sample for a write and the sample-clock time for a tick
// output stream: one status word per input word, in order
// config channel: cfg_index selects prebuffer level, latency cap or block size;
//   always ready, write only while the block is idle
// one input word per cycle while s_tready is high; the state update and the
//   ram access of a word happen in its accept cycle, the ram read data lands
//   in the next cycle alongside the word in the pending stage, and the word
//   leaves from the output register
// a stalled receiver holds the output word; one more input word is still
//   taken into the pending stage, then s_tready drops until the output drains
// reset clears pointers, fill count, pacing state and the config registers
//   (3840, 9600, 480); the sample ram is not cleared and needs no sweep, the
//   fill count keeps unwritten entries from being read
module paced_audio_ring_buffer_unit #(
  parameter int RING_DEPTH = 16384
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input words
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [15:0] sample_in, [63:16] now_frames
  input  wire logic [1:0]  s_tuser,   // [1:0] opcode
  // status words
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [55:0] m_tdata,   // [15:0] sample_out, [16] sample_valid,
                                      // [17] dropped_oldest, [18] deliver,
                                      // [33:19] trimmed_frames, [48:34] fill_level,
                                      // [49] running, [55:50] zero
  // config writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);

  localparam int PW = $clog2(RING_DEPTH);

  logic                             accept;
  logic                             slot_free;
  logic                             ram_we;
  logic                             ram_re;
  logic [PW-1:0]                    ram_addr;
  logic [parb_pkg::SampleWidth-1:0] ram_wdata;
  logic [parb_pkg::SampleWidth-1:0] ram_rdata;
  parb_pkg::parb_result_t           result;

  assign s_tready  = slot_free;
  assign accept    = s_tvalid && slot_free;
  assign cfg_ready = 1'b1;

  // ring pointers, fill count, pacing state and config registers
  parb_core #(
    .RING_DEPTH (RING_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .opcode     (parb_pkg::parb_op_t'(s_tuser)),
    .sample_in  (s_tdata[15:0]),
    .now_frames (s_tdata[63:16]),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ram_we     (ram_we),
    .ram_re     (ram_re),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .result     (result)
  );

  // sample store, single port with registered read
  parb_ram #(
    .WIDTH (parb_pkg::SampleWidth),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // pending stage plus output register
  parb_out u_out (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .result    (result),
    .ram_rdata (ram_rdata),
    .slot_free (slot_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

@@ src/parb_ram.sv @@
`default_nettype none

module parb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

@@ src/parb_core.sv @@
`default_nettype none

module parb_core #(
  parameter int RING_DEPTH = 16384
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 accept,
  input  wire parb_pkg::parb_op_t                   opcode,
  input  wire logic [parb_pkg::SampleWidth-1:0]     sample_in,
  input  wire logic [parb_pkg::TimeWidth-1:0]       now_frames,
  input  wire logic                                 cfg_we,
  input  wire logic [1:0]                           cfg_index,
  input  wire logic [parb_pkg::CfgWidth-1:0]        cfg_data,
  output logic                                      ram_we,
  output logic                                      ram_re,
  output logic      [$clog2(RING_DEPTH)-1:0]        ram_addr,
  output logic      [parb_pkg::SampleWidth-1:0]     ram_wdata,
  output parb_pkg::parb_result_t                    result
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam int FW = $clog2(RING_DEPTH + 1);
  localparam int EW = (FW > parb_pkg::CfgWidth) ? FW : parb_pkg::CfgWidth;
  localparam int TW = parb_pkg::TimeWidth;

  logic [PW-1:0] read_pointer, read_pointer_next;
  logic [PW-1:0] write_pointer, write_pointer_next;
  logic [FW-1:0] fill_count, fill_count_next;
  logic          pacing_started, pacing_started_next;
  logic [TW-1:0] start_time, start_time_next;
  logic [TW-1:0] delivered_frames, delivered_frames_next;

  logic [parb_pkg::CfgWidth-1:0] prebuffer_frames;
  logic [parb_pkg::CfgWidth-1:0] max_buffered_frames;
  logic [parb_pkg::CfgWidth-1:0] frames_per_tick;

  logic [PW-1:0] rp_inc, wp_inc;
  logic          full;
  logic [EW-1:0] fill_e, cap_e, prebuf_e, trim_e, fill_next_e;
  logic [FW-1:0] trim_f;
  logic [FW:0]   rp_sum, rp_wrap;
  logic [TW-1:0] elapsed;
  logic [TW:0]   allowed;
  logic          late;

  assign rp_inc = (read_pointer == PW'(RING_DEPTH - 1)) ? '0 : read_pointer + 1'b1;
  assign wp_inc = (write_pointer == PW'(RING_DEPTH - 1)) ? '0 : write_pointer + 1'b1;
  assign full   = (fill_count == FW'(RING_DEPTH));

  assign fill_e   = EW'(fill_count);
  assign cap_e    = EW'(max_buffered_frames);
  assign prebuf_e = EW'(prebuffer_frames);
  assign trim_e   = fill_e - cap_e;
  assign trim_f   = FW'(trim_e);

  // trim never exceeds the depth, so one subtract wraps the pointer
  assign rp_sum  = (FW + 1)'(read_pointer) + (FW + 1)'(trim_f);
  assign rp_wrap = (rp_sum >= (FW + 1)'(RING_DEPTH)) ? rp_sum - (FW + 1)'(RING_DEPTH)
                                                     : rp_sum;

  // elapsed wraps with the clock; the slack sum keeps its carry
  assign elapsed = now_frames - start_time;
  assign allowed = {1'b0, elapsed} + (TW + 1)'(frames_per_tick);
  assign late    = ({1'b0, delivered_frames} > allowed);

  always_comb begin
    read_pointer_next     = read_pointer;
    write_pointer_next    = write_pointer;
    fill_count_next       = fill_count;
    pacing_started_next   = pacing_started;
    start_time_next       = start_time;
    delivered_frames_next = delivered_frames;
    ram_we                = 1'b0;
    ram_re                = 1'b0;
    ram_addr              = read_pointer;
    ram_wdata             = sample_in;
    result                = '0;
    if (accept) begin
      unique case (opcode)
        parb_pkg::OP_WRITE: begin
          ram_we             = 1'b1;
          ram_addr           = write_pointer;
          write_pointer_next = wp_inc;
          if (full) begin
            read_pointer_next     = rp_inc;
            result.dropped_oldest = 1'b1;
          end else begin
            fill_count_next = fill_count + 1'b1;
          end
        end
        parb_pkg::OP_TICK: begin
          if (!pacing_started) begin
            if (fill_e >= prebuf_e) begin
              pacing_started_next   = 1'b1;
              start_time_next       = now_frames;
              delivered_frames_next = '0;
            end
          end else begin
            if (fill_e > cap_e) begin
              result.trimmed_frames = trim_e[parb_pkg::LevelWidth-1:0];
              read_pointer_next     = PW'(rp_wrap);
              fill_count_next       = FW'(cap_e);
            end
            if (!late) begin
              result.deliver        = 1'b1;
              delivered_frames_next = delivered_frames + TW'(frames_per_tick);
            end
          end
        end
        parb_pkg::OP_PULL: begin
          if (fill_count != '0) begin
            ram_re              = 1'b1;
            result.sample_valid = 1'b1;
            read_pointer_next   = rp_inc;
            fill_count_next     = fill_count - 1'b1;
          end
        end
        parb_pkg::OP_STOP: begin
          pacing_started_next = 1'b0;
        end
        default: begin
          pacing_started_next = pacing_started;
        end
      endcase
    end
    fill_next_e       = EW'(fill_count_next);
    result.fill_level = fill_next_e[parb_pkg::LevelWidth-1:0];
    result.running    = pacing_started_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer        <= '0;
      write_pointer       <= '0;
      fill_count          <= '0;
      pacing_started      <= 1'b0;
      start_time          <= '0;
      delivered_frames    <= '0;
      prebuffer_frames    <= parb_pkg::PREBUFFER_RESET;
      max_buffered_frames <= parb_pkg::MAX_BUF_RESET;
      frames_per_tick     <= parb_pkg::PER_TICK_RESET;
    end else begin
      read_pointer     <= read_pointer_next;
      write_pointer    <= write_pointer_next;
      fill_count       <= fill_count_next;
      pacing_started   <= pacing_started_next;
      start_time       <= start_time_next;
      delivered_frames <= delivered_frames_next;
      if (cfg_we) begin
        unique case (cfg_index)
          parb_pkg::REG_PREBUFFER: prebuffer_frames    <= cfg_data;
          parb_pkg::REG_MAX_BUF:   max_buffered_frames <= cfg_data;
          parb_pkg::REG_PER_TICK:  frames_per_tick     <= cfg_data;
          default: begin
            prebuffer_frames <= prebuffer_frames;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ src/parb_out.sv @@
`default_nettype none

module parb_out (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             accept,
  input  wire parb_pkg::parb_result_t           result,
  input  wire logic [parb_pkg::SampleWidth-1:0] ram_rdata,
  output logic                                  slot_free,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [55:0]                      m_tdata
);

  // pending stage waits for the ram read data, output stage holds the word
  logic                             pend_valid;
  parb_pkg::parb_result_t           pend;
  logic                             out_valid;
  parb_pkg::parb_result_t           out_res;
  logic [parb_pkg::SampleWidth-1:0] out_sample;
  logic                             move;

  assign move      = pend_valid && (!out_valid || m_tready);
  assign slot_free = !pend_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= result;
    end
    if (move) begin
      out_res    <= pend;
      out_sample <= pend.sample_valid ? ram_rdata : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_res.running, out_res.fill_level, out_res.trimmed_frames,
                     out_res.deliver, out_res.dropped_oldest, out_res.sample_valid,
                     out_sample};

endmodule

`default_nettype wire

@@ bench/paced_audio_ring_buffer_unit_tb.sv @@
`default_nettype none

module paced_audio_ring_buffer_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH  = 16384;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int PRINT_LIMIT = 100;
  // the channel carries two index bits, the fourth index selects nothing
  localparam logic [1:0] REG_NONE = 2'd3;

  // one input word as queued for the driver, gap is idle cycles before it
  typedef struct {
    parb_pkg::parb_op_t op;
    logic [15:0]        smp;
    logic [47:0]        stamp;
    int                 gap;
  } ring_word_t;

  // status word in the bit order of m_tdata
  typedef struct packed {
    logic [5:0]  pad;
    logic        running;
    logic [14:0] level;
    logic [14:0] trimmed;
    logic        deliver;
    logic        dropped;
    logic        valid;
    logic [15:0] smp;
  } ring_status_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata   = '0;   // [15:0] sample_in, [63:16] now_frames
  logic [1:0]  s_tuser   = '0;   // [1:0] opcode
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [55:0] m_tdata;          // [15:0] sample_out, [16] sample_valid,
                                 // [17] dropped_oldest, [18] deliver,
                                 // [33:19] trimmed_frames, [48:34] fill_level,
                                 // [49] running, [55:50] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [14:0] cfg_data  = '0;

  paced_audio_ring_buffer_unit #(
    .RING_DEPTH(RING_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // own copy of the ring and pacing state, updated on every accepted word
  // ---------------------------------------------------------------------------
  logic [15:0] ring_mem [RING_DEPTH];
  int          rd_ptr, wr_ptr, level;
  logic        pacing;
  logic [47:0] t_start, sent_frames;
  int          cfg_prebuf, cfg_cap, cfg_block;

  ring_word_t   word_q[$];        // words waiting for the driver
  ring_status_t due_status_q[$];  // predicted status words, oldest first
  ring_word_t   cur_word;         // word currently on the input bus
  logic         word_taken = 1'b0;
  int           held = 0;
  int           stall_left = 0;
  int           reg_writes = 0;
  int           errors = 0;
  int           cycles = 0;
  logic         tx_gap_on = 1'b1;
  logic         rx_stall_on = 1'b1;
  logic [47:0]  tick_time = '0;
  int           blk_gen = 480;

  function automatic ring_status_t advance_ring(ring_word_t w);
    ring_status_t r;
    int           cut;
    logic [63:0]  since;
    r = '0;
    case (w.op)
      parb_pkg::OP_WRITE: begin
        // full ring: oldest sample makes room
        if (level >= RING_DEPTH) begin
          rd_ptr = (rd_ptr + 1) % RING_DEPTH;
          level--;
          r.dropped = 1'b1;
        end
        ring_mem[wr_ptr] = w.smp;
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        level++;
      end
      parb_pkg::OP_TICK: begin
        if (!pacing) begin
          // waits until the prebuffer level is held, then marks the start
          if (level >= cfg_prebuf) begin
            pacing      = 1'b1;
            t_start     = w.stamp;
            sent_frames = '0;
          end
        end else begin
          if (level > cfg_cap) begin
            cut       = level - cfg_cap;
            rd_ptr    = (rd_ptr + cut) % RING_DEPTH;
            level     = cfg_cap;
            r.trimmed = cut[14:0];
          end
          // elapsed time wraps with the 48 bit sample clock
          since = {16'd0, w.stamp - t_start};
          if (!({16'd0, sent_frames} > since + 64'(cfg_block))) begin
            r.deliver   = 1'b1;
            sent_frames = sent_frames + 48'(cfg_block);
          end
        end
      end
      parb_pkg::OP_PULL: begin
        if (level > 0) begin
          r.smp   = ring_mem[rd_ptr];
          r.valid = 1'b1;
          rd_ptr  = (rd_ptr + 1) % RING_DEPTH;
          level--;
        end
      end
      default: pacing = 1'b0;
    endcase
    r.level   = level[14:0];
    r.running = pacing;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= PRINT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // rising edge: config writes, accepted words and status words
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    ring_status_t got, want;
    word_taken = 1'b0;
    if (rst) begin
      rd_ptr      = 0;
      wr_ptr      = 0;
      level       = 0;
      pacing      = 1'b0;
      t_start     = '0;
      sent_frames = '0;
      cfg_prebuf  = int'(parb_pkg::PREBUFFER_RESET);
      cfg_cap     = int'(parb_pkg::MAX_BUF_RESET);
      cfg_block   = int'(parb_pkg::PER_TICK_RESET);
      due_status_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        // only the three listed registers hold anything
        case (cfg_index)
          parb_pkg::REG_PREBUFFER: cfg_prebuf = int'(cfg_data);
          parb_pkg::REG_MAX_BUF:   cfg_cap    = int'(cfg_data);
          parb_pkg::REG_PER_TICK:  cfg_block  = int'(cfg_data);
          default: ;
        endcase
        reg_writes++;
      end
      // the status word out now belongs to an older input word
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (due_status_q.size() == 0) begin
          errors++;
          if (errors <= PRINT_LIMIT)
            $display("%0t: status word with none expected, expected nothing, actual %0h",
                     $time, m_tdata);
        end else begin
          want = due_status_q.pop_front();
          check_field("sample_out", want.smp, got.smp);
          check_field("sample_valid", 16'(want.valid), 16'(got.valid));
          check_field("dropped_oldest", 16'(want.dropped), 16'(got.dropped));
          check_field("deliver", 16'(want.deliver), 16'(got.deliver));
          check_field("trimmed_frames", 16'(want.trimmed), 16'(got.trimmed));
          check_field("fill_level", 16'(want.level), 16'(got.level));
          check_field("running", 16'(want.running), 16'(got.running));
          check_field("padding", 16'(want.pad), 16'(got.pad));
        end
      end
      if (s_tvalid && s_tready) begin
        word_taken = 1'b1;
        due_status_q.push_back(advance_ring(cur_word));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // falling edge: input driver, holds a word until taken, then the next one
  // after its gap
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      held = 0;
    end else if (!s_tvalid || word_taken) begin
      if (word_q.size() != 0 && held >= word_q[0].gap) begin
        cur_word = word_q.pop_front();
        s_tuser  <= cur_word.op;
        s_tdata  <= {cur_word.stamp, cur_word.smp};
        s_tvalid <= 1'b1;
        held = 0;
      end else begin
        s_tvalid <= 1'b0;
        if (word_q.size() != 0) held++;
      end
    end
  end

  // falling edge: receiver, mostly ready, short stalls and now and then a long one
  always @(negedge clk) begin
    int pick;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!rx_stall_on) begin
      m_tready <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        m_tready <= 1'b1;
      end else begin
        stall_left = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(7, 23);
        m_tready <= 1'b0;
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_word(parb_pkg::parb_op_t op, logic [15:0] smp,
                                     logic [47:0] stamp);
    ring_word_t w;
    int         pick;
    w.op    = op;
    w.smp   = smp;
    w.stamp = stamp;
    w.gap   = 0;
    if (tx_gap_on) begin
      pick = $urandom_range(0, 99);
      if (pick >= 95)      w.gap = $urandom_range(8, 24);
      else if (pick >= 65) w.gap = $urandom_range(1, 3);
    end
    word_q.push_back(w);
  endfunction

  // block idle: nothing queued, nothing on the bus, nothing owed
  task automatic wait_drained();
    do @(negedge clk);
    while (word_q.size() != 0 || s_tvalid || due_status_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    int seen;
    seen = reg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    wait (reg_writes != seen);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [47:0] any_stamp();
    return {16'($urandom()), $urandom()};
  endfunction

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int                 pick, pre, cap;
    parb_pkg::parb_op_t op;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: pull and stop on an empty idle ring, waiting tick,
    // extreme samples stored and the first two read back
    queue_word(parb_pkg::OP_PULL, 16'h1234, any_stamp());
    queue_word(parb_pkg::OP_STOP, 16'hFFFF, any_stamp());
    queue_word(parb_pkg::OP_TICK, 16'h0000, 48'd0);
    queue_word(parb_pkg::OP_WRITE, 16'h7FFF, any_stamp());
    queue_word(parb_pkg::OP_WRITE, 16'h8000, any_stamp());
    queue_word(parb_pkg::OP_WRITE, 16'h0000, any_stamp());
    queue_word(parb_pkg::OP_WRITE, 16'hFFFF, any_stamp());
    queue_word(parb_pkg::OP_WRITE, 16'h5555, any_stamp());
    queue_word(parb_pkg::OP_WRITE, 16'hAAAA, any_stamp());
    queue_word(parb_pkg::OP_PULL, 16'h0000, any_stamp());
    queue_word(parb_pkg::OP_PULL, 16'h0000, any_stamp());
    queue_word(parb_pkg::OP_TICK, 16'h0000, 48'd1000);
    queue_word(parb_pkg::OP_STOP, 16'h0000, any_stamp());
    wait_drained();

    // zero prebuffer starts at once, cap of one, zero sized blocks;
    // start at the top of the clock so the next tick sees it wrap
    write_reg(parb_pkg::REG_PREBUFFER, 15'd0);
    write_reg(parb_pkg::REG_MAX_BUF, 15'd1);
    write_reg(parb_pkg::REG_PER_TICK, 15'd0);
    queue_word(parb_pkg::OP_TICK, 16'h0000, 48'hFFFF_FFFF_FFFF);
    queue_word(parb_pkg::OP_TICK, 16'h0000, 48'd5);
    queue_word(parb_pkg::OP_TICK, 16'h0000, 48'd5);
    queue_word(parb_pkg::OP_STOP, 16'h0000, any_stamp());
    queue_word(parb_pkg::OP_PULL, 16'h0000, any_stamp());
    queue_word(parb_pkg::OP_PULL, 16'h0000, any_stamp());
    wait_drained();

    // zero cap trims the ring empty, a ring-deep block runs ahead until refused
    write_reg(parb_pkg::REG_PREBUFFER, 15'd1);
    write_reg(parb_pkg::REG_MAX_BUF, 15'd0);
    write_reg(parb_pkg::REG_PER_TICK, 15'd16384);
    write_reg(REG_NONE, 15'h7FFF);
    repeat (3) queue_word(parb_pkg::OP_WRITE, 16'($urandom()), any_stamp());
    repeat (4) queue_word(parb_pkg::OP_TICK, 16'h0000, 48'd100);
    wait_drained();

    // long fill without idling, pacing starts part way through
    write_reg(parb_pkg::REG_PREBUFFER, 15'd200);
    write_reg(parb_pkg::REG_MAX_BUF, 15'd16384);
    write_reg(parb_pkg::REG_PER_TICK, 15'd16384);
    tx_gap_on = 1'b0;
    rx_stall_on <= 1'b0;
    tick_time = any_stamp();
    queue_word(parb_pkg::OP_STOP, 16'h0000, any_stamp());
    for (int i = 0; i < 330; i++) begin
      queue_word(parb_pkg::OP_WRITE, 16'($urandom()), any_stamp());
      if (i % 64 == 63) begin
        tick_time = tick_time + 48'd16384;
        queue_word(parb_pkg::OP_TICK, 16'($urandom()), tick_time);
      end
    end
    repeat (3) begin
      tick_time = tick_time + 48'(16384 * $urandom_range(0, 2));
      queue_word(parb_pkg::OP_TICK, 16'($urandom()), tick_time);
    end
    repeat (2) queue_word(parb_pkg::OP_PULL, 16'($urandom()), any_stamp());
    repeat (4) queue_word(parb_pkg::OP_WRITE, 16'($urandom()), any_stamp());
    wait_drained();

    // drop the cap on a well filled ring: one deep trim, then down to nothing
    write_reg(parb_pkg::REG_MAX_BUF, 15'd1);
    queue_word(parb_pkg::OP_TICK, 16'($urandom()), tick_time);
    queue_word(parb_pkg::OP_PULL, 16'($urandom()), any_stamp());
    queue_word(parb_pkg::OP_PULL, 16'($urandom()), any_stamp());
    wait_drained();
    write_reg(parb_pkg::REG_MAX_BUF, 15'd0);
    queue_word(parb_pkg::OP_WRITE, 16'($urandom()), any_stamp());
    queue_word(parb_pkg::OP_TICK, 16'($urandom()), tick_time + 48'd16384);
    wait_drained();

    // random phases: small settings so pacing starts early, a few extremes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin pre = 16; cap = 64; blk_gen = 8; end
        1: begin pre = 0; cap = 1; blk_gen = 1; end
        3: begin pre = 4; cap = 16384; blk_gen = 16384; end
        5: begin pre = 32; cap = 8; blk_gen = 3; end
        6: begin
          pre     = $urandom_range(0, 24);
          cap     = $urandom_range(1, 48);
          blk_gen = $urandom_range(0, 4);
        end
        default: begin
          pre     = $urandom_range(0, 48);
          cap     = $urandom_range(1, 96);
          blk_gen = $urandom_range(1, 24);
        end
      endcase
      write_reg(parb_pkg::REG_PREBUFFER, 15'(pre));
      write_reg(parb_pkg::REG_MAX_BUF, 15'(cap));
      write_reg(parb_pkg::REG_PER_TICK, 15'(blk_gen));
      // one phase each with no gaps and with no stalls
      tx_gap_on = (ph != 4);
      rx_stall_on <= (ph != 6);
      for (int n = 0; n < 160; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)      op = parb_pkg::OP_WRITE;
        else if (pick < 70) op = parb_pkg::OP_TICK;
        else if (pick < 96) op = parb_pkg::OP_PULL;
        else                op = parb_pkg::OP_STOP;
        if (op == parb_pkg::OP_TICK) begin
          // mostly near the paced rate, some held or jumping ticks
          pick = $urandom_range(0, 99);
          if (pick < 85 && pick >= 20)
            tick_time = tick_time + 48'($urandom_range(0, 2 * blk_gen));
          else if (pick >= 85 && pick < 95)
            tick_time = tick_time + 48'($urandom_range(0, 100000));
          else if (pick >= 95)
            tick_time = any_stamp();
          queue_word(op, 16'($urandom()), tick_time);
        end else begin
          queue_word(op, 16'($urandom()), any_stamp());
        end
      end
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
